### sv/servo_pose_sequencer_assert.svh
// Assertion macros for the servo pose sequencer.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SERVO_POSE_SEQUENCER_ASSERT_SVH
`define SERVO_POSE_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("servo pose sequencer check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("servo pose sequencer check failed");

`endif

### sv/sps_pkg.sv
package sps_pkg;

    localparam int NUM_SERVOS = 5;
    localparam int NUM_MOVES  = 12;

    typedef logic [7:0] angle_t;
    typedef logic [2:0] servo_sel_t;
    typedef logic [4:0] period_t;
    typedef logic [3:0] move_idx_t;
    typedef angle_t [NUM_SERVOS-1:0] angles_t;

    // Command codes carried in the cmd field.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Command bytes with a special meaning on a bus write.
    localparam logic [7:0] BYTE_LAST_BIN = 8'd2;
    localparam logic [7:0] BYTE_STOP     = 8'd3;
    localparam logic [7:0] BYTE_RESUME   = 8'd4;

    localparam move_idx_t FIRST_MOVE = 4'd0;
    localparam move_idx_t BIN_MOVE   = 4'd6;
    localparam move_idx_t REST_START = 4'd9;
    localparam move_idx_t END_MOVE   = 4'(NUM_MOVES);

    // Servo five is element 4, servo one is element 0.
    localparam angles_t RESET_ANGLES = {8'd85, 8'd55, 8'd180, 8'd140, 8'd60};

    typedef struct packed {
        logic       pair;
        servo_sel_t sa;
        angle_t     ta;
        servo_sel_t sb;
        angle_t     tb;
        period_t    per;
    } move_t;

    typedef struct packed {
        logic       found;
        move_idx_t  idx;
    } move_pick_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] angle_one;
        logic [7:0] angle_two;
        logic [7:0] angle_three;
        logic [7:0] angle_four;
        logic [7:0] angle_five;
        logic       read_data;
        logic       busy_res;
        logic       halted;
    } rsp_t;

    // Waypoint table. The drop move takes its first target from bin_target.
    function automatic move_t move_info(input move_idx_t idx);
        move_t m;
        case (idx)
            4'd0:    m = '{1'b1, 3'd1, 8'd120, 3'd0, 8'd0,   5'd10};
            4'd1:    m = '{1'b1, 3'd3, 8'd70,  3'd2, 8'd135, 5'd10};
            4'd2:    m = '{1'b0, 3'd4, 8'd172, 3'd4, 8'd172, 5'd10};
            4'd3:    m = '{1'b1, 3'd3, 8'd40,  3'd2, 8'd153, 5'd10};
            4'd4:    m = '{1'b0, 3'd0, 8'd40,  3'd0, 8'd40,  5'd10};
            4'd5:    m = '{1'b1, 3'd3, 8'd70,  3'd2, 8'd150, 5'd10};
            4'd6:    m = '{1'b0, 3'd4, 8'd0,   3'd4, 8'd0,   5'd10};
            4'd7:    m = '{1'b1, 3'd3, 8'd5,   3'd2, 8'd105, 5'd10};
            4'd8:    m = '{1'b0, 3'd0, 8'd0,   3'd0, 8'd0,   5'd20};
            4'd9:    m = '{1'b1, 3'd3, 8'd55,  3'd2, 8'd180, 5'd10};
            4'd10:   m = '{1'b1, 3'd0, 8'd60,  3'd1, 8'd140, 5'd15};
            4'd11:   m = '{1'b0, 3'd4, 8'd85,  3'd4, 8'd85,  5'd10};
            default: m = '{1'b0, 3'd0, 8'd0,   3'd0, 8'd0,   5'd10};
        endcase
        return m;
    endfunction

    function automatic angle_t bin_target(input logic [1:0] bin);
        angle_t t;
        case (bin)
            2'd0:    t = 8'd70;
            2'd1:    t = 8'd93;
            default: t = 8'd120;
        endcase
        return t;
    endfunction

    function automatic angle_t toward(input angle_t p, input angle_t t);
        angle_t r;
        if (p < t) begin
            r = p + 8'd1;
        end
        else if (p > t) begin
            r = p - 8'd1;
        end
        else begin
            r = p;
        end
        return r;
    endfunction

endpackage

### sv/servo_pose_sequencer.sv
// Channel    Payload   Handshake               Meaning
// req        req_t     req_valid / req_stall    tick, bus write or bus read
// rsp        rsp_t     rsp_valid / rsp_stall    angles and status after each item
//
// Every accepted request yields exactly one response. The request passes through
// the input register and then the single update stage, which writes the sequencer
// state and the response register together. A new request is taken in every cycle
// unless the response side stalls while the input register is full.
// Reset clears both pipeline valid bits and puts the arm in its power-up pose.
// A stall on the response side holds the response register; the request side
// then stalls only while the input register is also full.
module servo_pose_sequencer
    import sps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_item,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_item
);

    // A move counts as reached when every servo it drives sits at its target.
    function automatic logic at_target(input move_idx_t i, input angles_t a,
                                       input logic [1:0] bin);
        move_t  m;
        angle_t tgt;
        m   = move_info(i);
        tgt = (i == BIN_MOVE) ? bin_target(bin) : m.ta;
        return (a[m.sa] == tgt) && (!m.pair || (a[m.sb] == m.tb));
    endfunction

    // Finds the first move at or after start that still needs time. A paired
    // move that is already at its targets is skipped; a single move never is.
    function automatic move_pick_t find_move(input move_idx_t start, input angles_t a,
                                             input logic [1:0] bin);
        move_pick_t pick;
        move_t      m;
        pick = '{1'b0, FIRST_MOVE};
        for (int k = 0; k < NUM_MOVES; k++) begin
            m = move_info(4'(k));
            if (!pick.found && (4'(k) >= start)
                && (!m.pair || !at_target(4'(k), a, bin))) begin
                pick = '{1'b1, 4'(k)};
            end
        end
        return pick;
    endfunction

    // Input register.
    logic      s1_valid_reg;
    req_t      s1_item_reg;
    logic      advance;

    // Sequencer state.
    angles_t   angles_reg,  angles_next;
    logic      stop_reg,    stop_next;
    logic      done_reg,    done_next;
    logic      running_reg, running_next;
    move_idx_t move_reg,    move_next;
    logic [1:0] bin_reg,    bin_next;
    period_t   tick_reg,    tick_next;
    logic      extra_reg,   extra_next;

    // Response register.
    logic      rsp_valid_reg;
    rsp_t      rsp_item_reg, rsp_next;

    // The update stage moves whenever the response register is empty or being taken.
    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // Update logic: one enter-move search is shared by the tick and write paths.
    move_t      cur;
    angles_t    stepped;
    move_idx_t  enter_start;
    angles_t    enter_angles;
    logic [1:0] enter_bin;
    logic       do_enter;
    move_pick_t pick;
    move_t      picked;
    logic       read_bit;
    logic       write_bin;

    always_comb
    begin
        cur       = move_info(move_reg);
        write_bin = (s1_item_reg.data_byte <= BYTE_LAST_BIN);

        // One slew step toward the current move's targets.
        stepped = angles_reg;
        for (int k = 0; k < NUM_SERVOS; k++) begin
            if (3'(k) == cur.sa) begin
                stepped[k] = toward(angles_reg[k],
                                    (move_reg == BIN_MOVE) ? bin_target(bin_reg) : cur.ta);
            end
            else if (cur.pair && (3'(k) == cur.sb)) begin
                stepped[k] = toward(angles_reg[k], cur.tb);
            end
        end

        angles_next  = angles_reg;
        stop_next    = stop_reg;
        done_next    = done_reg;
        running_next = running_reg;
        move_next    = move_reg;
        bin_next     = bin_reg;
        tick_next    = tick_reg;
        extra_next   = extra_reg;
        read_bit     = 1'b0;
        do_enter     = 1'b0;
        enter_start  = REST_START;
        enter_angles = angles_reg;
        enter_bin    = bin_reg;

        case (s1_item_reg.cmd)
            CMD_TICK:
            begin
                if (running_reg) begin
                    if ((tick_reg + 5'd1) < cur.per) begin
                        tick_next = tick_reg + 5'd1;
                    end
                    else begin
                        tick_next = '0;
                        if (extra_reg) begin
                            extra_next = 1'b0;
                        end
                        else begin
                            angles_next = stepped;
                        end
                        if (at_target(move_reg, angles_next, bin_reg)) begin
                            do_enter     = 1'b1;
                            enter_start  = move_reg + 4'd1;
                            enter_angles = angles_next;
                        end
                    end
                end
            end
            CMD_WRITE:
            begin
                if (s1_item_reg.data_byte == BYTE_STOP) begin
                    stop_next    = 1'b1;
                    running_next = 1'b0;
                    done_next    = 1'b1;
                    move_next    = FIRST_MOVE;
                    tick_next    = '0;
                    extra_next   = 1'b0;
                end
                else if (s1_item_reg.data_byte == BYTE_RESUME) begin
                    stop_next    = 1'b0;
                    running_next = 1'b1;
                    do_enter     = 1'b1;
                end
                else if (!running_reg) begin
                    if (stop_reg) begin
                        done_next = 1'b1;
                    end
                    else begin
                        running_next = 1'b1;
                        do_enter     = 1'b1;
                        if (write_bin) begin
                            bin_next    = s1_item_reg.data_byte[1:0];
                            enter_bin   = s1_item_reg.data_byte[1:0];
                            enter_start = FIRST_MOVE;
                        end
                    end
                end
            end
            CMD_READ:
            begin
                read_bit  = done_reg;
                done_next = 1'b0;
            end
            default:
            begin
                read_bit = 1'b0;
            end
        endcase

        pick   = find_move(enter_start, enter_angles, enter_bin);
        picked = move_info(pick.idx);
        if (do_enter) begin
            tick_next = '0;
            if (pick.found) begin
                move_next  = pick.idx;
                extra_next = !picked.pair;
            end
            else begin
                running_next = 1'b0;
                done_next    = 1'b1;
                move_next    = FIRST_MOVE;
                extra_next   = 1'b0;
            end
        end

        rsp_next.angle_one   = angles_next[0];
        rsp_next.angle_two   = angles_next[1];
        rsp_next.angle_three = angles_next[2];
        rsp_next.angle_four  = angles_next[3];
        rsp_next.angle_five  = angles_next[4];
        rsp_next.read_data   = read_bit;
        rsp_next.busy_res    = running_next;
        rsp_next.halted      = stop_next;
    end

    // Pipeline valid bits and sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            angles_reg    <= RESET_ANGLES;
            stop_reg      <= 1'b0;
            done_reg      <= 1'b0;
            running_reg   <= 1'b0;
            move_reg      <= FIRST_MOVE;
            bin_reg       <= 2'd0;
            tick_reg      <= '0;
            extra_reg     <= 1'b0;
        end
        else begin
            if (req_valid && !req_stall) begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance) begin
                s1_valid_reg <= 1'b0;
            end

            if (advance) begin
                rsp_valid_reg <= 1'b1;
                angles_reg    <= angles_next;
                stop_reg      <= stop_next;
                done_reg      <= done_next;
                running_reg   <= running_next;
                move_reg      <= move_next;
                bin_reg       <= bin_next;
                tick_reg      <= tick_next;
                extra_reg     <= extra_next;
            end
            else if (!rsp_stall) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall) begin
            s1_item_reg <= req_item;
        end
        if (advance) begin
            rsp_item_reg <= rsp_next;
        end
    end

    // A latched emergency stop always leaves the sequencer idle.
`include "servo_pose_sequencer_assert.svh"
    `SPS_ASSERT_NOW(a_stop_is_idle, stop_reg, !running_reg)
    // When idle, the move pointer, tick counter and extra period are all parked.
    `SPS_ASSERT_NOW(a_idle_parked, !running_reg,
                    (move_reg == FIRST_MOVE) && (tick_reg == '0) && !extra_reg)
    // While running, the tick counter stays inside the current move's period.
    `SPS_ASSERT_NOW(a_tick_in_period, running_reg,
                    (move_reg < END_MOVE) && (tick_reg < cur.per))
    // The response shown reflects the state that the update stage just wrote.
    `SPS_ASSERT_NEXT(a_rsp_matches_state, advance,
                     (rsp_item_reg.busy_res == running_reg)
                     && (rsp_item_reg.halted == stop_reg))

endmodule
